FILE: rtl/tes_pkg.sv
// shared constants, codes, command struct and saturating add for the timed event slot table
// no dependencies; used by tes_ctrl, tes_dp and timed_event_slot_table
package tes_pkg;

    localparam int SLOTS  = 32;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OP_W   = 2;
    localparam int TIME_W = 32;
    localparam int ID_W   = 16;
    localparam int IVL_W  = 16;
    localparam int KIND_W = 3;
    localparam int SLOT_W = 5;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_FIRED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DONE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEARED = 3'd4;

    localparam logic [ID_W-1:0]   ID_FREE     = '0;
    localparam logic [ID_W-1:0]   ID_RESERVED = '1;
    localparam logic [TIME_W-1:0] TIME_MAX    = '1;

    typedef struct packed {
        logic             load;     // item accepted this cycle
        logic             alloc;    // try to claim a slot
        logic             clear;    // free every slot
        logic             refuse;   // answer refused
        logic             done;     // close the scan
        logic             rd_en;    // read slot rd_addr into the evaluate stage
        logic [IDX_W-1:0] rd_addr;
    } cmd_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

FILE: rtl/tes_ctrl.sv
// controller for the timed event slot table: decodes the op and sequences the slot scan
// depends on tes_pkg
module tes_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tes_pkg::OP_W-1:0]    op,
    output logic                        busy,
    output tes_pkg::cmd_t               cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_CLEAR,
        S_REFUSE,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic                       busy_reg;
    logic [tes_pkg::IDX_W-1:0]  cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= '0;
                        case (op)
                            tes_pkg::OP_TICK:  state_reg <= S_SCAN;
                            tes_pkg::OP_ALLOC: state_reg <= S_ALLOC;
                            tes_pkg::OP_CLEAR: state_reg <= S_CLEAR;
                            default:           state_reg <= S_REFUSE;
                        endcase
                    end
                end
                S_ALLOC, S_CLEAR, S_REFUSE, S_DONE:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                S_SCAN:
                begin
                    if (cnt_reg == tes_pkg::IDX_W'(tes_pkg::SLOTS - 1))
                        state_reg <= S_FLUSH;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                // last slot is evaluated here
                S_FLUSH:
                begin
                    state_reg <= S_DONE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.load    = start && (state_reg == S_IDLE);
        cmd.alloc   = (state_reg == S_ALLOC);
        cmd.clear   = (state_reg == S_CLEAR);
        cmd.refuse  = (state_reg == S_REFUSE);
        cmd.done    = (state_reg == S_DONE);
        cmd.rd_en   = (state_reg == S_SCAN);
        cmd.rd_addr = cnt_reg;
    end

    assign busy = busy_reg;

endmodule

FILE: rtl/tes_dp.sv
// datapath for the timed event slot table: slot memories, active bits, scan evaluate stage
// and the result register; depends on tes_pkg
module tes_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tes_pkg::cmd_t                   cmd,
    input  logic [tes_pkg::TIME_W-1:0]      now,
    input  logic [tes_pkg::ID_W-1:0]        event_id,
    input  logic [tes_pkg::TIME_W-1:0]      duration,
    input  logic [tes_pkg::IVL_W-1:0]       interval,
    output logic                            strobe,
    output logic [tes_pkg::KIND_W-1:0]      kind,
    output logic [tes_pkg::SLOT_W-1:0]      slot,
    output logic [tes_pkg::ID_W-1:0]        event_id_res,
    output logic                            last
);

    // latched item
    logic [tes_pkg::TIME_W-1:0] now_reg;
    logic [tes_pkg::ID_W-1:0]   id_reg;
    logic [tes_pkg::TIME_W-1:0] dur_reg;
    logic [tes_pkg::IVL_W-1:0]  ivl_reg;

    // slot storage; entries are read on every scan but only acted on while their active bit is set
    logic [tes_pkg::ID_W-1:0]   ident_mem  [tes_pkg::SLOTS];
    logic [tes_pkg::TIME_W-1:0] end_mem    [tes_pkg::SLOTS];
    logic [tes_pkg::TIME_W-1:0] next_mem   [tes_pkg::SLOTS];
    logic [tes_pkg::IVL_W-1:0]  period_mem [tes_pkg::SLOTS];
    logic [tes_pkg::SLOTS-1:0]  active_reg;

    // evaluate stage
    logic                       ev_vld_reg;
    logic [tes_pkg::IDX_W-1:0]  ev_idx_reg;
    logic [tes_pkg::ID_W-1:0]   rd_ident_reg;
    logic [tes_pkg::TIME_W-1:0] rd_end_reg;
    logic [tes_pkg::TIME_W-1:0] rd_next_reg;
    logic [tes_pkg::IVL_W-1:0]  rd_period_reg;

    // result register
    logic                       strobe_reg;
    logic                       strobe_next;
    logic [tes_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [tes_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [tes_pkg::ID_W-1:0]   res_id_reg, res_id_next;
    logic                       last_reg, last_next;

    logic                       ev_active;
    logic                       fire;
    logic                       expire;
    logic                       free_found;
    logic [tes_pkg::IDX_W-1:0]  free_idx;
    logic                       id_ok;
    logic                       alloc_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= now;
            id_reg  <= event_id;
            dur_reg <= duration;
            ivl_reg <= interval;
        end
    end

    assign ev_active = ev_vld_reg && active_reg[ev_idx_reg];
    assign fire      = ev_active && (rd_end_reg >= now_reg) && (now_reg >= rd_next_reg);
    assign expire    = ev_active && (rd_end_reg < now_reg);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = tes_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = tes_pkg::IDX_W'(i);
            end
        end
    end

    assign id_ok    = (id_reg != tes_pkg::ID_FREE) && (id_reg != tes_pkg::ID_RESERVED);
    assign alloc_ok = cmd.alloc && id_ok && free_found;

    always_ff @(posedge clk)
    begin
        if (alloc_ok)
        begin
            ident_mem[free_idx]  <= id_reg;
            end_mem[free_idx]    <= tes_pkg::sat_add(now_reg, dur_reg);
            next_mem[free_idx]   <= now_reg;
            period_mem[free_idx] <= ivl_reg;
        end
        else if (fire)
        begin
            next_mem[ev_idx_reg] <= tes_pkg::sat_add(rd_next_reg,
                                                     tes_pkg::TIME_W'(rd_period_reg));
        end
        if (cmd.rd_en)
        begin
            rd_ident_reg  <= ident_mem[cmd.rd_addr];
            rd_end_reg    <= end_mem[cmd.rd_addr];
            rd_next_reg   <= next_mem[cmd.rd_addr];
            rd_period_reg <= period_mem[cmd.rd_addr];
            ev_idx_reg    <= cmd.rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            ev_vld_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            ev_vld_reg <= cmd.rd_en;
            strobe_reg <= strobe_next;
            if (cmd.clear)
                active_reg <= '0;
            else if (alloc_ok)
                active_reg[free_idx] <= 1'b1;
            else if (expire)
                active_reg[ev_idx_reg] <= 1'b0;
        end
    end

    always_comb
    begin
        strobe_next = 1'b1;
        kind_next   = tes_pkg::KIND_REFUSED;
        slot_next   = '0;
        res_id_next = '0;
        last_next   = 1'b1;
        if (fire)
        begin
            kind_next   = tes_pkg::KIND_FIRED;
            slot_next   = tes_pkg::SLOT_W'(ev_idx_reg);
            res_id_next = rd_ident_reg;
            last_next   = 1'b0;
        end
        else if (alloc_ok)
        begin
            kind_next   = tes_pkg::KIND_ALLOC;
            slot_next   = tes_pkg::SLOT_W'(free_idx);
            res_id_next = id_reg;
        end
        else if (cmd.clear)
            kind_next = tes_pkg::KIND_CLEARED;
        else if (cmd.done)
            kind_next = tes_pkg::KIND_DONE;
        else if (!(cmd.alloc || cmd.refuse))
            strobe_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        slot_reg   <= slot_next;
        res_id_reg <= res_id_next;
        last_reg   <= last_next;
    end

    assign strobe       = strobe_reg;
    assign kind         = kind_reg;
    assign slot         = slot_reg;
    assign event_id_res = res_id_reg;
    assign last         = last_reg;

endmodule

FILE: rtl/timed_event_slot_table.sv
// top level of the timed event slot table: controller plus datapath, with assertions
// depends on tes_pkg, tes_ctrl and tes_dp
//
// An item is taken when start is high and busy is low. Allocate, clear and any unknown op
// answer with one result, which leaves the output register as busy drops, so a new item of
// these kinds cannot be taken before the last one is answered. A tick reads the 32 slots one a
// cycle through a single read port and a registered evaluate stage, then closes with the scan
// done result, which leaves as busy drops; a new item can be taken once busy is low. Results
// leave through an output register, one a cycle, each marked by strobe for exactly one cycle;
// they cannot be held off. No clearing pass runs after reset.
module timed_event_slot_table
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tes_pkg::OP_W-1:0]        op,
    input  logic [tes_pkg::TIME_W-1:0]      now,
    input  logic [tes_pkg::ID_W-1:0]        event_id,
    input  logic [tes_pkg::TIME_W-1:0]      duration,
    input  logic [tes_pkg::IVL_W-1:0]       interval,
    output logic                            strobe,
    output logic [tes_pkg::KIND_W-1:0]      kind,
    output logic [tes_pkg::SLOT_W-1:0]      slot,
    output logic [tes_pkg::ID_W-1:0]        event_id_res,
    output logic                            last
);

    tes_pkg::cmd_t cmd;

    tes_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .busy  (busy),
        .cmd   (cmd)
    );

    tes_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .now          (now),
        .event_id     (event_id),
        .duration     (duration),
        .interval     (interval),
        .strobe       (strobe),
        .kind         (kind),
        .slot         (slot),
        .event_id_res (event_id_res),
        .last         (last)
    );

`ifndef SYNTH
    // an accepted item always makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // the final result of an item shows up as busy drops
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last)
        else $error("busy dropped without a final result");

    // fired results come only inside a scan and never close it
    a_fired_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == tes_pkg::KIND_FIRED |-> busy && !last)
        else $error("fired result outside a scan");

    // a scan reads slots only while it runs
    a_read_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> busy && !cmd.alloc && !cmd.clear)
        else $error("slot read outside a scan");
`endif

endmodule
